[design/cfe_pkg.sv]
package cfe_pkg;

   localparam logic [7:0]  PREAMBLE_BYTE = 8'hE6;
   localparam logic [7:0]  ESCAPE_BYTE   = 8'hE5;
   localparam logic [7:0]  SPECIAL_LOW   = 8'hE3;
   localparam logic [7:0]  SPECIAL_HIGH  = 8'hE6;
   localparam logic [15:0] CSUM_BASE     = 16'hFFFF;

   localparam int PREAMBLE_LEN = 4;
   localparam int PRE_CNT_W    = $clog2(PREAMBLE_LEN);

   // power of two so the pointers wrap on their own
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic        pre;
      logic [7:0]  data;
      logic        last;
      logic [15:0] csum;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      PH_PRE,
      PH_DATA,
      PH_CLO,
      PH_CHI
   } phase_type;

   function automatic logic is_special(input logic [7:0] b);
      return (b >= SPECIAL_LOW) && (b <= SPECIAL_HIGH);
   endfunction

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

[design/cfe_channel_if.sv]
interface cfe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface cfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

[design/cfe_front.sv]
module cfe_front (
   input  logic                      clock,
   input  logic                      reset,
   cfe_req_if.sink                   req_chan,
   input  cfe_pkg::queue_status_type q_stat,
   output logic                      push,
   output cfe_pkg::job_type          push_job
);
   import cfe_pkg::*;

   logic [15:0] sum_ff, sum_in;
   logic        odd_ff, odd_in;
   logic        start_ff, start_in;
   logic [15:0] addend;
   logic [15:0] new_sum;

   assign req_chan.ready = !q_stat.full;
   assign push           = req_chan.valid && !q_stat.full;

   always_comb begin
      addend  = odd_ff ? {req_chan.data_byte, 8'd0} : {8'd0, req_chan.data_byte};
      new_sum = ones_add(sum_ff, addend);

      push_job.pre  = start_ff;
      push_job.data = req_chan.data_byte;
      push_job.last = req_chan.last_byte;
      push_job.csum = CSUM_BASE - new_sum;

      sum_in   = sum_ff;
      odd_in   = odd_ff;
      start_in = start_ff;
      if (push) begin
         if (req_chan.last_byte) begin
            sum_in   = 16'd0;
            odd_in   = 1'b0;
            start_in = 1'b1;
         end else begin
            sum_in   = new_sum;
            odd_in   = !odd_ff;
            start_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= 16'd0;
         odd_ff   <= 1'b0;
         start_ff <= 1'b1;
      end else begin
         sum_ff   <= sum_in;
         odd_ff   <= odd_in;
         start_ff <= start_in;
      end
   end

endmodule

[design/cfe_queue.sv]
module cfe_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cfe_pkg::job_type          push_job,
   input  logic                      pop,
   output cfe_pkg::job_type          head_job,
   output cfe_pkg::queue_status_type q_stat
);
   import cfe_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign head_job     = entry_ff[rd_ptr_ff];
   assign q_stat.empty = (cnt_ff == '0);
   assign q_stat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[design/cfe_back.sv]
module cfe_back (
   input  logic                      clock,
   input  logic                      reset,
   input  cfe_pkg::job_type          head_job,
   input  cfe_pkg::queue_status_type q_stat,
   output logic                      pop,
   cfe_rsp_if.source                 rsp_chan
);
   import cfe_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [PRE_CNT_W-1:0] pre_cnt_ff, pre_cnt_in;
   logic                 tail_ff, tail_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 lor_ff, lor_in;

   phase_type eff_phase;
   logic      step;
   logic      elem_end;
   logic      job_done;
   logic      special;
   logic [7:0] raw;
   logic [7:0] cur_byte;

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.out_byte    = byte_ff;
   assign rsp_chan.last_of_run = lor_ff;

   // outputs of the sequencer
   always_comb begin
      step = !q_stat.empty && (!valid_ff || rsp_chan.ready);
      // a job without preamble starts straight at its data byte
      eff_phase = (phase_ff == PH_PRE && !head_job.pre) ? PH_DATA : phase_ff;
      case (eff_phase)
         PH_DATA: raw = head_job.data;
         PH_CLO:  raw = head_job.csum[7:0];
         PH_CHI:  raw = head_job.csum[15:8];
         default: raw = PREAMBLE_BYTE;
      endcase
      special = is_special(raw);
      if (eff_phase == PH_PRE) begin
         cur_byte = PREAMBLE_BYTE;
         elem_end = 1'b1;
      end else if (tail_ff) begin
         cur_byte = SPECIAL_HIGH - raw;
         elem_end = 1'b1;
      end else if (special) begin
         cur_byte = ESCAPE_BYTE;
         elem_end = 1'b0;
      end else begin
         cur_byte = raw;
         elem_end = 1'b1;
      end
      case (eff_phase)
         PH_DATA: job_done = elem_end && !head_job.last;
         PH_CHI:  job_done = elem_end;
         default: job_done = 1'b0;
      endcase
      pop = step && job_done;

      valid_in = step || (valid_ff && !rsp_chan.ready);
      byte_in  = step ? cur_byte : byte_ff;
      lor_in   = step ? job_done : lor_ff;
   end

   // next state
   always_comb begin
      phase_in   = phase_ff;
      pre_cnt_in = pre_cnt_ff;
      tail_in    = tail_ff;
      if (step) begin
         tail_in = !elem_end;
         case (eff_phase)
            PH_PRE: begin
               if (pre_cnt_ff == PRE_CNT_W'(PREAMBLE_LEN - 1)) begin
                  pre_cnt_in = '0;
                  phase_in   = PH_DATA;
               end else begin
                  pre_cnt_in = pre_cnt_ff + PRE_CNT_W'(1);
               end
            end
            PH_DATA: begin
               if (elem_end) begin
                  phase_in = head_job.last ? PH_CLO : PH_PRE;
               end
            end
            PH_CLO: begin
               if (elem_end) begin
                  phase_in = PH_CHI;
               end
            end
            PH_CHI: begin
               if (elem_end) begin
                  phase_in = PH_PRE;
               end
            end
            default: phase_in = PH_PRE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_PRE;
         pre_cnt_ff <= '0;
         tail_ff    <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         pre_cnt_ff <= pre_cnt_in;
         tail_ff    <= tail_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      lor_ff  <= lor_in;
   end

endmodule

[design/command_frame_escaper_top.sv]
// channel   dir  beat payload                       accepted when
// req_chan  in   data_byte[7:0], last_byte          valid && ready
// rsp_chan  out  out_byte[7:0], last_of_run         valid && ready
//
// Each command byte yields 1 to 10 line bytes (1 or 2 for the data byte, up to 8
// more for the preamble and checksum); the back sequencer sends one line byte per
// cycle while the queue holds a job and rsp_chan is not stalled.
// Request beats enter the job queue at one per cycle while it has room.
// Reset (synchronous) empties the queue and returns the checksum to a new frame.
// A stalled rsp_chan holds its beat; the front keeps accepting until the queue fills.
module command_frame_escaper_top (
   input  logic      clock,
   input  logic      reset,
   cfe_req_if.sink   req_chan,
   cfe_rsp_if.source rsp_chan
);
   import cfe_pkg::*;

   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          head_job;
   queue_status_type q_stat;

   cfe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .push     (push),
      .push_job (push_job)
   );

   cfe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_stat   (q_stat)
   );

   cfe_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .q_stat   (q_stat),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

`ifndef ASSERT_OFF
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("job popped from empty queue");

   a_pop_marks_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_chan.valid && rsp_chan.last_of_run)
      else $error("finished job without last_of_run beat");

   a_accept_queued: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !q_stat.empty)
      else $error("accepted beat missing from queue");
`endif

endmodule
